>>> hdl/slnt_pkg.sv
`timescale 1ns / 1ps

package slnt_pkg;

  // Default table depth.
  localparam int CAPACITY_DEF = 64;

  // Field widths of the words on the ports.
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int PAGE_W   = 31;
  localparam int SLOT_W   = 31;
  localparam int EIDX_W   = 8;
  localparam int STATUS_W = 3;
  localparam int FIDX_W   = 7;
  localparam int COUNT_W  = 7;
  localparam int ENTRY_W  = KEY_W + PAGE_W + SLOT_W;

  // Command codes on the input port.
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOCATE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SETNEXT = 2'd3;

  // Status codes on the result port.
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL         = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_RECORD    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_POINTER  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RESERVED_KEY = 3'd4;

  // Operations after classification by the front end.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOCATE  = 3'd1;
  localparam logic [OP_W-1:0] OP_READ    = 3'd2;
  localparam logic [OP_W-1:0] OP_SETNEXT = 3'd3;
  localparam logic [OP_W-1:0] OP_REJ_KEY = 3'd4;
  localparam logic [OP_W-1:0] OP_REJ_PTR = 3'd5;

  // One classified command as it sits in the queue.
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [KEY_W-1:0]  key;
    logic [PAGE_W-1:0]        page;
    logic [SLOT_W-1:0]        slot;
    logic [EIDX_W-1:0]        idx;
    logic [PAGE_W-1:0]        next_page;
  } cmd_t;

endpackage

>>> hdl/slnt_ram.sv
`timescale 1ns / 1ps

module slnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/slnt_front.sv
`timescale 1ns / 1ps

module slnt_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [slnt_pkg::CMD_W-1:0]          in_command,
  input  logic signed [slnt_pkg::KEY_W-1:0]   in_key,
  input  logic [slnt_pkg::PAGE_W-1:0]         in_record_page,
  input  logic [slnt_pkg::SLOT_W-1:0]         in_record_slot,
  input  logic [slnt_pkg::EIDX_W-1:0]         in_entry_index,
  input  logic signed [slnt_pkg::KEY_W-1:0]   in_next_page,
  output logic                                q_valid,
  input  logic                                q_pop,
  output slnt_pkg::cmd_t                      q_data
);
  import slnt_pkg::*;

  localparam int QDEPTH = 2;

  cmd_t        fifo_r [QDEPTH];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  cmd_t        cls;

  // Decode the command and settle the checks that need no table state.
  always_comb begin
    cls.key       = in_key;
    cls.page      = in_record_page;
    cls.slot      = in_record_slot;
    cls.idx       = in_entry_index;
    cls.next_page = in_next_page[PAGE_W-1:0];
    case (in_command)
      CMD_INSERT:  cls.op = (in_key == '0) ? OP_REJ_KEY : OP_INSERT;
      CMD_LOCATE:  cls.op = OP_LOCATE;
      CMD_READ:    cls.op = OP_READ;
      CMD_SETNEXT: cls.op = in_next_page[KEY_W-1] ? OP_REJ_PTR : OP_SETNEXT;
      default:     cls.op = OP_LOCATE;
    endcase
  end

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_data   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> hdl/slnt_back.sv
`timescale 1ns / 1ps

module slnt_back #(
  parameter int CAPACITY = slnt_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  output logic                                q_pop,
  input  slnt_pkg::cmd_t                      q_data,
  output logic                                ram_we,
  output logic [$clog2(CAPACITY)-1:0]         ram_waddr,
  output logic [slnt_pkg::ENTRY_W-1:0]        ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]         ram_raddr,
  input  logic [slnt_pkg::ENTRY_W-1:0]        ram_rdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [slnt_pkg::STATUS_W-1:0]       out_status,
  output logic [slnt_pkg::FIDX_W-1:0]         out_found_index,
  output logic signed [slnt_pkg::KEY_W-1:0]   out_found_key,
  output logic [slnt_pkg::PAGE_W-1:0]         out_found_page,
  output logic [slnt_pkg::SLOT_W-1:0]         out_found_slot,
  output logic [slnt_pkg::COUNT_W-1:0]        out_entry_count,
  output logic [slnt_pkg::PAGE_W-1:0]         out_sibling_page
);
  import slnt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > EIDX_W) ? CW : EIDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_LOC  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]             state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [AW-1:0]          j_r, j_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [PAGE_W-1:0]      sib_r, sib_nxt;
  logic [STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic [FIDX_W-1:0]      res_fidx_r, res_fidx_nxt;
  logic [ENTRY_W-1:0]     res_entry_r, res_entry_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_load;
  logic [STATUS_W-1:0]    out_status_r;
  logic [FIDX_W-1:0]      out_fidx_r;
  logic [ENTRY_W-1:0]     out_entry_r;
  logic [COUNT_W-1:0]     out_count_r;
  logic [PAGE_W-1:0]      out_sib_r;
  logic signed [KEY_W-1:0] rd_key;
  logic [ENTRY_W-1:0]     new_entry;

  assign rd_key    = ram_rdata[ENTRY_W-1 -: KEY_W];
  assign new_entry = {cmd_r.key, cmd_r.page, cmd_r.slot};

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    j_nxt          = j_r;
    count_nxt      = count_r;
    sib_nxt        = sib_r;
    res_status_nxt = res_status_r;
    res_fidx_nxt   = res_fidx_r;
    res_entry_nxt  = res_entry_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_load       = 1'b0;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = new_entry;
    ram_raddr      = j_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          cmd_nxt        = q_data;
          res_status_nxt = ST_OK;
          res_fidx_nxt   = '0;
          res_entry_nxt  = '0;
          state_nxt      = S_DONE;
          case (q_data.op)
            OP_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else if (count_r == '0) begin
                ram_we    = 1'b1;
                ram_wdata = {q_data.key, q_data.page, q_data.slot};
                count_nxt = count_r + CW'(1);
              end else begin
                // Walk down from the top entry, moving larger keys up.
                ram_raddr = AW'(count_r - CW'(1));
                j_nxt     = AW'(count_r - CW'(1));
                state_nxt = S_INS;
              end
            end
            OP_LOCATE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_NO_RECORD;
              end else begin
                ram_raddr = '0;
                j_nxt     = '0;
                state_nxt = S_LOC;
              end
            end
            OP_READ: begin
              if (IW'(q_data.idx) >= IW'(count_r)) begin
                res_status_nxt = ST_NO_RECORD;
              end else begin
                ram_raddr = AW'(q_data.idx);
                state_nxt = S_RD;
              end
            end
            OP_SETNEXT: sib_nxt = q_data.next_page;
            OP_REJ_KEY: res_status_nxt = ST_RESERVED_KEY;
            OP_REJ_PTR: res_status_nxt = ST_BAD_POINTER;
            default:    res_status_nxt = ST_OK;
          endcase
        end
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = j_r + AW'(1);
        if (rd_key > cmd_r.key) begin
          ram_wdata = ram_rdata;
          if (j_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            j_nxt     = j_r - AW'(1);
            ram_raddr = j_r - AW'(1);
          end
        end else begin
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_LOC: begin
        if (rd_key == cmd_r.key) begin
          res_fidx_nxt = FIDX_W'(j_r);
          state_nxt    = S_DONE;
        end else if (rd_key > cmd_r.key) begin
          res_status_nxt = ST_NO_RECORD;
          res_fidx_nxt   = FIDX_W'(j_r);
          state_nxt      = S_DONE;
        end else if (CW'(j_r) + CW'(1) == count_r) begin
          res_status_nxt = ST_NO_RECORD;
          res_fidx_nxt   = FIDX_W'(count_r);
          state_nxt      = S_DONE;
        end else begin
          j_nxt     = j_r + AW'(1);
          ram_raddr = j_r + AW'(1);
        end
      end

      S_RD: begin
        res_entry_nxt = ram_rdata;
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sib_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sib_r       <= sib_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    j_r          <= j_nxt;
    res_status_r <= res_status_nxt;
    res_fidx_r   <= res_fidx_nxt;
    res_entry_r  <= res_entry_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_fidx_r   <= res_fidx_r;
      out_entry_r  <= res_entry_r;
      out_count_r  <= COUNT_W'(count_r);
      out_sib_r    <= sib_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_index  = out_fidx_r;
  assign out_found_key    = out_entry_r[ENTRY_W-1 -: KEY_W];
  assign out_found_page   = out_entry_r[SLOT_W +: PAGE_W];
  assign out_found_slot   = out_entry_r[SLOT_W-1:0];
  assign out_entry_count  = out_count_r;
  assign out_sibling_page = out_sib_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> count_r == $past(count_r) + CW'(1))
    else $error("entry count moved by other than one insert");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE || state_r == S_INS || state_r == S_PUT))
    else $error("table write outside an insert");

  a_shift_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS || state_r == S_PUT) |-> count_r != CW'(CAPACITY))
    else $error("shift started on a full table");
`endif

endmodule

>>> hdl/sorted_leaf_node_table.sv
`timescale 1ns / 1ps

// Sorted leaf node table: one leaf of a B+ tree, holding up to CAPACITY
// entries of (signed key, record page, record slot) in ascending key order,
// plus a next-sibling page pointer. Each input word gives exactly one result
// word. The sequencer pops a queued word when it is idle, does the work of
// the command and then loads the result register. Insert walks down from
// the top entry and moves each larger key up by one slot, using the table
// memory's one read port and one write port. An insert into an empty table
// writes entry zero directly, and a refused insert writes no entry. Locate
// scans up from entry zero, one entry per cycle, and stops at the first
// equal or larger key or at the last stored entry. An out-of-range read,
// set next and a refused pointer need no table access. The longest commands
// are an insert of a key smaller than every one of CAPACITY minus one
// stored entries and a locate that scans all CAPACITY entries. A result
// that waits on the output holds the sequencer.
// A two-word queue between the input classifier and the table sequencer lets
// new words be taken while the sequencer works or while a result waits.
// Key 0 is refused on insert, negative sibling pointers are refused, and
// table entries need no clearing after reset because only entries below the
// stored count are ever read.
module sorted_leaf_node_table #(
  parameter int CAPACITY = slnt_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [slnt_pkg::CMD_W-1:0]          in_command,
  input  logic signed [slnt_pkg::KEY_W-1:0]   in_key,
  input  logic [slnt_pkg::PAGE_W-1:0]         in_record_page,
  input  logic [slnt_pkg::SLOT_W-1:0]         in_record_slot,
  input  logic [slnt_pkg::EIDX_W-1:0]         in_entry_index,
  input  logic signed [slnt_pkg::KEY_W-1:0]   in_next_page,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [slnt_pkg::STATUS_W-1:0]       out_status,
  output logic [slnt_pkg::FIDX_W-1:0]         out_found_index,
  output logic signed [slnt_pkg::KEY_W-1:0]   out_found_key,
  output logic [slnt_pkg::PAGE_W-1:0]         out_found_page,
  output logic [slnt_pkg::SLOT_W-1:0]         out_found_slot,
  output logic [slnt_pkg::COUNT_W-1:0]        out_entry_count,
  output logic [slnt_pkg::PAGE_W-1:0]         out_sibling_page
);
  import slnt_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  // Classified commands waiting for the sequencer.
  logic           q_valid;
  logic           q_pop;
  cmd_t           q_data;

  // Table memory port.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // The front end decodes each word and queues it.
  slnt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_key         (in_key),
    .in_record_page (in_record_page),
    .in_record_slot (in_record_slot),
    .in_entry_index (in_entry_index),
    .in_next_page   (in_next_page),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_data         (q_data)
  );

  // The back end owns the table, the count and the sibling pointer.
  slnt_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_data           (q_data),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found_index  (out_found_index),
    .out_found_key    (out_found_key),
    .out_found_page   (out_found_page),
    .out_found_slot   (out_found_slot),
    .out_entry_count  (out_entry_count),
    .out_sibling_page (out_sibling_page)
  );

  // Key, page and slot of every entry share one memory word.
  slnt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
